[rtl/meiu_pkg.sv]
`default_nettype none

package meiu_pkg;

  // default operand width
  localparam int unsigned WIDTH_DEF = 32;

  // modulus value after reset
  localparam int unsigned MOD_RESET = 2;

  // operation of the shared arithmetic unit
  typedef enum logic {
    ALU_MUL = 1'b0,  // (x * y) mod m, bit-serial shift-and-add
    ALU_DIV = 1'b1   // x / y and x % y, restoring division
  } alu_op_t;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

`default_nettype wire

[rtl/meiu_if.sv]
`default_nettype none

// request channel: one operation per transaction
interface meiu_req_if #(
  parameter int unsigned WIDTH = meiu_pkg::WIDTH_DEF
) ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;

  modport source (output valid, output mode, output base, output exponent, input ready);
  modport sink   (input valid, input mode, input base, input exponent, output ready);
endinterface

// response channel: one result per transaction
interface meiu_rsp_if #(
  parameter int unsigned WIDTH = meiu_pkg::WIDTH_DEF
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;
  logic             no_inverse;

  modport source (output valid, output result, output no_inverse, input ready);
  modport sink   (input valid, input result, input no_inverse, output ready);
endinterface

`default_nettype wire

[rtl/meiu_alu.sv]
`default_nettype none

// Shared bit-serial unit: one bit of the operand per cycle, WIDTH steps per
// operation. MUL gives (x * y) mod m for x < m, DIV gives x / y and x % y.
// Results are valid in the cycle done is high and hold until the next start.
module meiu_alu #(
  parameter int unsigned WIDTH = meiu_pkg::WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire meiu_pkg::alu_req_t  req,
  input  wire logic [WIDTH-1:0]    x,
  input  wire logic [WIDTH-1:0]    y,
  input  wire logic [WIDTH-1:0]    m,
  output logic                     done,
  output logic [WIDTH-1:0]         rem,
  output logic [WIDTH-1:0]         quo
);

  localparam int unsigned CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  logic                busy;
  logic [CW-1:0]       cnt;
  meiu_pkg::alu_op_t   op_q;
  logic [WIDTH-1:0]    acc;
  logic [WIDTH-1:0]    sh;
  logic [WIDTH-1:0]    opa;
  logic [WIDTH-1:0]    opm;
  logic [WIDTH-1:0]    acc_next;
  logic                qbit;

  logic [WIDTH:0]      dbl;
  logic [WIDTH:0]      dbl_red;
  logic [WIDTH:0]      sum;
  logic [WIDTH:0]      sum_red;
  logic [WIDTH:0]      trial;
  logic                trial_ge;

  // one step of either operation
  always_comb begin
    // multiply: acc = 2*acc mod m, then + a mod m when the multiplier bit is set
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, opm}) ? (dbl - {1'b0, opm}) : dbl;
    sum     = {1'b0, dbl_red[WIDTH-1:0]} + {1'b0, opa};
    sum_red = (sum >= {1'b0, opm}) ? (sum - {1'b0, opm}) : sum;
    // divide: shift in the next dividend bit, subtract when it fits
    trial    = {acc, sh[WIDTH-1]};
    trial_ge = (trial >= {1'b0, opa});
    unique case (op_q)
      meiu_pkg::ALU_MUL: begin
        acc_next = sh[WIDTH-1] ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
        qbit     = 1'b0;
      end
      meiu_pkg::ALU_DIV: begin
        acc_next = trial_ge ? WIDTH'(trial - {1'b0, opa}) : trial[WIDTH-1:0];
        qbit     = trial_ge;
      end
      default: begin
        acc_next = acc;
        qbit     = 1'b0;
      end
    endcase
  end

  // sequencing of the unit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op_q <= req.op;
        acc  <= '0;
        quo  <= '0;
        opa  <= (req.op == meiu_pkg::ALU_DIV) ? y : x;
        sh   <= (req.op == meiu_pkg::ALU_DIV) ? x : y;
        opm  <= m;
      end else if (busy) begin
        acc <= acc_next;
        quo <= {quo[WIDTH-2:0], qbit};
        sh  <= {sh[WIDTH-2:0], 1'b0};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = acc;

endmodule

`default_nettype wire

[rtl/modular_exp_and_inverse_unit.sv]
`default_nettype none

// Modular exponentiation and inverse modulo a programmable modulus (register 0,
// reset value 2). Mode 0 returns base^exponent mod modulus by right-to-left
// square-and-multiply; mode 1 returns the inverse of base by the extended
// Euclidean algorithm, or 0 with no_inverse set when none exists. A modulus
// below 2 returns 0 with no_inverse equal to the mode. All arithmetic runs on
// one shared bit-serial multiply/divide unit, and the block takes one request
// at a time. Mode 0 costs one reduction plus one squaring per exponent bit up
// to the highest set bit and one multiplication per set bit. Mode 1 costs one
// reduction plus one division and one multiplication for each Euclid step;
// 32 bits need at most 45 steps. A finished result waits in the output
// register while the next request is taken.
module modular_exp_and_inverse_unit #(
  parameter int unsigned WIDTH = meiu_pkg::WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [((WIDTH > 32) ? 4 : 3)-1:0]      paddr,
  input  wire logic [((WIDTH > 32) ? 64 : 32)-1:0]    pwdata,
  output logic      [((WIDTH > 32) ? 64 : 32)-1:0]    prdata,
  output logic                                        pready,
  // data channels
  meiu_req_if.sink                                    req,
  meiu_rsp_if.source                                  rsp
);

  localparam int unsigned DW      = (WIDTH > 32) ? 64 : 32;
  localparam int unsigned AW      = (WIDTH > 32) ? 4 : 3;
  localparam int unsigned IDX_LSB = AW - 1;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_RED     = 8'b0000_0010,
    ST_EXP     = 8'b0000_0100,
    ST_EXP_MUL = 8'b0000_1000,
    ST_EXP_SQ  = 8'b0001_0000,
    ST_INV_DIV = 8'b0010_0000,
    ST_INV_MUL = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [WIDTH-1:0]    modulus;
  logic                mode_q;
  logic [WIDTH-1:0]    exp_q;
  logic [WIDTH-1:0]    acc;
  logic [WIDTH-1:0]    sq;
  logic [WIDTH-1:0]    r0;
  logic [WIDTH-1:0]    r1;
  logic [WIDTH-1:0]    s0;
  logic [WIDTH-1:0]    s1;
  logic [WIDTH-1:0]    res;
  logic                flag;
  logic                out_valid;
  logic [WIDTH-1:0]    out_result;
  logic                out_flag;

  meiu_pkg::alu_req_t  alu_req;
  logic [WIDTH-1:0]    alu_x;
  logic [WIDTH-1:0]    alu_y;
  logic                alu_done;
  logic [WIDTH-1:0]    alu_rem;
  logic [WIDTH-1:0]    alu_quo;

  logic                m_small;
  logic                reg_sel;
  logic [WIDTH-1:0]    s_diff;
  logic [WIDTH-1:0]    s2;

  // register decode
  assign reg_sel = (paddr[AW-1:IDX_LSB] == '0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DW'(modulus) : '0;

  assign m_small = (modulus[WIDTH-1:1] == '0);

  // Bezout coefficient update: s0 - q*s1 mod m
  assign s_diff = s0 - alu_rem;
  assign s2     = (s0 >= alu_rem) ? s_diff : (s_diff + modulus);

  // requests to the shared unit
  always_comb begin
    alu_req = '{start: 1'b0, op: meiu_pkg::ALU_MUL};
    alu_x   = '0;
    alu_y   = '0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid && !m_small) begin
          alu_req = '{start: 1'b1, op: meiu_pkg::ALU_DIV};
          alu_x   = req.base;
          alu_y   = modulus;
        end
      end
      ST_RED: begin
        if (alu_done && mode_q && (alu_rem > WIDTH'(1))) begin
          alu_req = '{start: 1'b1, op: meiu_pkg::ALU_DIV};
          alu_x   = modulus;
          alu_y   = alu_rem;
        end
      end
      ST_EXP: begin
        if (exp_q != '0) begin
          alu_req = '{start: 1'b1, op: meiu_pkg::ALU_MUL};
          alu_x   = exp_q[0] ? acc : sq;
          alu_y   = sq;
        end
      end
      ST_EXP_MUL: begin
        if (alu_done) begin
          alu_req = '{start: 1'b1, op: meiu_pkg::ALU_MUL};
          alu_x   = sq;
          alu_y   = sq;
        end
      end
      ST_INV_DIV: begin
        if (alu_done) begin
          alu_req = '{start: 1'b1, op: meiu_pkg::ALU_MUL};
          alu_x   = alu_quo;
          alu_y   = s1;
        end
      end
      ST_INV_MUL: begin
        if (alu_done && (r1 != '0)) begin
          alu_req = '{start: 1'b1, op: meiu_pkg::ALU_DIV};
          alu_x   = r0;
          alu_y   = r1;
        end
      end
      default: ;
    endcase
  end

  meiu_alu #(
    .WIDTH (WIDTH)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .x    (alu_x),
    .y    (alu_y),
    .m    (modulus),
    .done (alu_done),
    .rem  (alu_rem),
    .quo  (alu_quo)
  );

  // sequencer, configuration register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      modulus   <= WIDTH'(meiu_pkg::MOD_RESET);
    end else begin
      if (psel && penable && pwrite && reg_sel) begin
        modulus <= pwdata[WIDTH-1:0];
      end
      // the done state reloads the output register itself
      if (rsp.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            mode_q <= req.mode;
            exp_q  <= req.exponent;
            if (m_small) begin
              res   <= '0;
              flag  <= req.mode;
              state <= ST_DONE;
            end else begin
              state <= ST_RED;
            end
          end
        end
        ST_RED: begin
          if (alu_done) begin
            if (!mode_q) begin
              acc   <= WIDTH'(1);
              sq    <= alu_rem;
              state <= ST_EXP;
            end else if (alu_rem == '0) begin
              res   <= '0;
              flag  <= 1'b1;
              state <= ST_DONE;
            end else if (alu_rem == WIDTH'(1)) begin
              res   <= WIDTH'(1);
              flag  <= 1'b0;
              state <= ST_DONE;
            end else begin
              r0    <= modulus;
              r1    <= alu_rem;
              s0    <= '0;
              s1    <= WIDTH'(1);
              state <= ST_INV_DIV;
            end
          end
        end
        // no set bits left: the remaining squarings cannot change the result
        ST_EXP: begin
          if (exp_q == '0) begin
            res   <= acc;
            flag  <= 1'b0;
            state <= ST_DONE;
          end else if (exp_q[0]) begin
            state <= ST_EXP_MUL;
          end else begin
            state <= ST_EXP_SQ;
          end
        end
        ST_EXP_MUL: begin
          if (alu_done) begin
            acc   <= alu_rem;
            state <= ST_EXP_SQ;
          end
        end
        ST_EXP_SQ: begin
          if (alu_done) begin
            sq    <= alu_rem;
            exp_q <= exp_q >> 1;
            state <= ST_EXP;
          end
        end
        ST_INV_DIV: begin
          if (alu_done) begin
            r0    <= r1;
            r1    <= alu_rem;
            state <= ST_INV_MUL;
          end
        end
        ST_INV_MUL: begin
          if (alu_done) begin
            s0 <= s1;
            s1 <= s2;
            if (r1 == '0) begin
              // gcd is in r0; the inverse is the coefficient now moving to s0
              res   <= (r0 == WIDTH'(1)) ? s1 : '0;
              flag  <= (r0 != WIDTH'(1));
              state <= ST_DONE;
            end else begin
              state <= ST_INV_DIV;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_result <= res;
            out_flag   <= flag;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.result     = out_result;
  assign rsp.no_inverse = out_flag;

endmodule

`default_nettype wire

[rtl/meiu_checker.sv]
`default_nettype none

module meiu_checker #(
  parameter int unsigned WIDTH = meiu_pkg::WIDTH_DEF
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [WIDTH-1:0] out_result,
  input wire logic             out_flag
);

  // one request at a time: the input closes after each transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after a transaction");

  // a missing inverse always comes with a zero result
  a_flag_zero_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_flag) |-> (out_result == '0))
    else $error("no_inverse set with a non-zero result");

  // a stalled response stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("response withdrawn before it was taken");

  // a stalled response keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_result) && $stable(out_flag)))
    else $error("response payload changed while stalled");

endmodule

bind modular_exp_and_inverse_unit meiu_checker #(
  .WIDTH (WIDTH)
) u_meiu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_result (rsp.result),
  .out_flag   (rsp.no_inverse)
);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned W = meiu_pkg::WIDTH_DEF;

  // operation codes of the mode field
  localparam logic MODE_EXP = 1'b0;
  localparam logic MODE_INV = 1'b1;

  // register map
  localparam logic [2:0] MODULUS_ADDR = 3'd0;

  // directed rows either carry their answer or leave it to the predictor
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam int IDLE_PCT       = 37;
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 200;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [W-1:0] result;
    logic         no_inverse;
  } answer_t;

  typedef struct packed {
    logic    typed;
    answer_t ans;
  } answer_note_t;

  typedef struct packed {
    logic [W-1:0] modulus;
    logic         mode;
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic         typed;
    logic [W-1:0] result;
    logic         no_inverse;
  } probe_t;

  localparam answer_note_t FROM_PREDICTOR = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  meiu_req_if #(.WIDTH(W)) req_ch ();
  meiu_rsp_if #(.WIDTH(W)) rsp_ch ();

  modular_exp_and_inverse_unit #(.WIDTH(W)) DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // directed stimulus: reset modulus, degenerate moduli, extremes, special cases
  probe_t directed_probes [25] = '{
    '{32'd2, MODE_EXP, 32'd3, 32'd5, TYPED, 32'd1, 1'b0},
    '{32'd2, MODE_INV, 32'd1, 32'hFFFF_FFFF, TYPED, 32'd1, 1'b0},
    '{32'd2, MODE_INV, 32'd2, 32'd0, TYPED, 32'd0, 1'b1},
    '{32'd0, MODE_EXP, 32'd5, 32'd3, TYPED, 32'd0, 1'b0},
    '{32'd0, MODE_INV, 32'd5, 32'd3, TYPED, 32'd0, 1'b1},
    '{32'd1, MODE_EXP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, 32'd0, 1'b0},
    '{32'd1, MODE_INV, 32'hFFFF_FFFF, 32'd0, TYPED, 32'd0, 1'b1},
    '{32'hFFFF_FFFF, MODE_EXP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, MODE_EXP, 32'hFFFF_FFFE, 32'd0, TYPED, 32'd1, 1'b0},
    '{32'hFFFF_FFFF, MODE_EXP, 32'd0, 32'd0, TYPED, 32'd1, 1'b0},
    '{32'hFFFF_FFFF, MODE_INV, 32'd0, 32'h1234_5678, TYPED, 32'd0, 1'b1},
    '{32'hFFFF_FFFF, MODE_INV, 32'hFFFF_FFFF, 32'd0, TYPED, 32'd0, 1'b1},
    '{32'hFFFF_FFFF, MODE_INV, 32'd2, 32'd0, PREDICTED, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, MODE_INV, 32'd3, 32'hDEAD_BEEF, PREDICTED, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, MODE_EXP, 32'hFFFF_FFFE, 32'hFFFF_FFFF, PREDICTED, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, MODE_EXP, 32'h8000_0001, 32'h8000_0000, PREDICTED, 32'd0, 1'b0},
    '{32'hFFFF_FFFB, MODE_INV, 32'hFFFF_FFFA, 32'd0, PREDICTED, 32'd0, 1'b0},
    '{32'hFFFF_FFFB, MODE_INV, 32'hFFFF_FFFC, 32'd0, TYPED, 32'd1, 1'b0},
    '{32'hFFFF_FFFB, MODE_EXP, 32'hFFFF_FFFA, 32'hFFFF_FFFF, PREDICTED, 32'd0, 1'b0},
    '{32'hFFFF_FFFB, MODE_EXP, 32'h1234_5678, 32'd1, PREDICTED, 32'd0, 1'b0},
    '{32'd3, MODE_INV, 32'd2, 32'd0, PREDICTED, 32'd0, 1'b0},
    '{32'd3, MODE_EXP, 32'hFFFF_FFFF, 32'hFFFF_FFFE, PREDICTED, 32'd0, 1'b0},
    '{32'h8000_0000, MODE_INV, 32'h8000_0000, 32'd0, TYPED, 32'd0, 1'b1},
    '{32'h8000_0000, MODE_INV, 32'h7FFF_FFFF, 32'd0, PREDICTED, 32'd0, 1'b0},
    '{32'h8000_0000, MODE_INV, 32'd6, 32'd0, PREDICTED, 32'd0, 1'b0}
  };

  answer_t      expected_answers [$];
  answer_note_t typed_answers [$];
  answer_note_t accepted_note;
  answer_t      oldest_answer;
  logic [W-1:0] modulus_copy;
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           jitter_on;
  bit           stall_request;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // power or inverse of one request under the given modulus
  function automatic answer_t predict_answer(logic md, logic [W-1:0] b, logic [W-1:0] e,
                                             logic [W-1:0] m);
    answer_t         a;
    longint unsigned mm;
    longint unsigned acc;
    longint unsigned sq;
    longint          r0, r1, r2, t0, t1, t2, q;
    a.result     = '0;
    a.no_inverse = 1'b0;
    mm = 64'(m);
    if (mm < 2) begin
      // no ring: flag follows the mode
      a.no_inverse = md;
    end else if (md == MODE_EXP) begin
      acc = 1;
      sq  = b % mm;
      for (int i = 0; i < W; i++) begin
        if (e[i]) acc = (acc * sq) % mm;
        sq = (sq * sq) % mm;
      end
      a.result = acc[W-1:0];
    end else begin
      // extended Euclid on signed coefficients, normalised at the end
      r0 = longint'(mm);
      r1 = longint'(b % mm);
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q  = r0 / r1;
        r2 = r0 - q * r1;
        t2 = t0 - q * t1;
        r0 = r1;
        r1 = r2;
        t0 = t1;
        t1 = t2;
      end
      if (r0 == 1) begin
        if (t0 < 0) t0 = t0 + longint'(mm);
        a.result = t0[W-1:0];
      end else begin
        a.no_inverse = 1'b1;
      end
    end
    return a;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
  endtask

  // accepted requests: queue the typed answer or the predicted one
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      accepted_note = (typed_answers.size() != 0) ? typed_answers.pop_front() : FROM_PREDICTOR;
      if (accepted_note.typed)
        expected_answers.push_back(accepted_note.ans);
      else
        expected_answers.push_back(predict_answer(req_ch.mode, req_ch.base, req_ch.exponent,
                                                  modulus_copy));
    end
  end

  // accepted results against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_answers.size() == 0) begin
        report("result with nothing outstanding", '0, 64'(rsp_ch.result));
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (rsp_ch.result !== oldest_answer.result)
          report("result", 64'(oldest_answer.result), 64'(rsp_ch.result));
        if (rsp_ch.no_inverse !== oldest_answer.no_inverse)
          report("no_inverse", 64'(oldest_answer.no_inverse), 64'(rsp_ch.no_inverse));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("modular_exp_and_inverse_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver: random back-pressure, one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp_ch.ready <= !(jitter_on && ($urandom_range(99) < IDLE_PCT));
      end
    end
  end

  // one request transaction, entered and left at a falling edge
  task automatic send_item(logic md, logic [W-1:0] b, logic [W-1:0] e, answer_note_t note);
    while (jitter_on && ($urandom_range(99) < IDLE_PCT)) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    typed_answers.push_back(note);
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= md;
    req_ch.base     <= b;
    req_ch.exponent <= e;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    @(negedge clk);
  endtask

  // hold the sender until every outstanding result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_answers.size() != 0) @(negedge clk);
  endtask

  // modulus access: optional write, then read back
  task automatic access_modulus(bit do_write, logic [W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    paddr   <= MODULUS_ADDR;
    pwrite  <= do_write;
    pwdata  <= value;
    if (do_write) begin
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      modulus_copy = value;
      @(negedge clk);
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== modulus_copy) report("modulus read-back", 64'(modulus_copy), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // random transactions under one modulus
  task automatic run_phase(logic [W-1:0] m, int count, int short_count, bit hold_rx);
    logic         md;
    logic [W-1:0] b;
    logic [W-1:0] e;
    wait_drained();
    access_modulus(1'b1, m);
    if (hold_rx) stall_request = 1'b1;
    for (int i = 0; i < count; i++) begin
      md = 1'($urandom_range(1));
      case ($urandom_range(9))
        0, 1, 2, 3, 4: b = $urandom;
        5:             b = $urandom_range(20);
        6:             b = m + $urandom_range(2) - 1;
        7:             b = m * $urandom_range(3);
        8:             b = {W{1'b1}};
        default:       b = $urandom_range(1) ? m - 1 : m + 1;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: e = $urandom;
        6, 7:             e = $urandom_range(8);
        8:                e = '0;
        default:          e = {W{1'b1}};
      endcase
      // short exponents finish quickly and fill the block during a hold-off
      if (i < short_count) begin
        md = MODE_EXP;
        e  = $urandom_range(15);
      end
      send_item(md, b, e, FROM_PREDICTOR);
    end
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_EXP;
    req_ch.base     = '0;
    req_ch.exponent = '0;
    jitter_on       = 1'b1;
    stall_request   = 1'b0;
    modulus_copy    = meiu_pkg::MOD_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset value of the modulus
    access_modulus(1'b0, '0);

    // directed table
    foreach (directed_probes[k]) begin
      if (directed_probes[k].modulus != modulus_copy) begin
        wait_drained();
        access_modulus(1'b1, directed_probes[k].modulus);
      end
      send_item(directed_probes[k].mode, directed_probes[k].base, directed_probes[k].exponent,
                {directed_probes[k].typed, directed_probes[k].result,
                 directed_probes[k].no_inverse});
    end

    // random part over a spread of moduli
    run_phase(32'hFFFF_FFFB, 31, 6, 1'b1);
    run_phase($urandom | 32'h8000_0000, 31, 0, 1'b0);
    run_phase($urandom_range(100, 2), 31, 0, 1'b0);
    jitter_on = 1'b0;
    run_phase(32'hFFFF_FFFF, 31, 0, 1'b0);
    jitter_on = 1'b1;
    run_phase(32'd2, 10, 0, 1'b0);
    run_phase(32'd0, 10, 0, 1'b0);
    run_phase(32'd1, 10, 0, 1'b0);
    run_phase(32'h8000_0000, 31, 0, 1'b0);
    run_phase($urandom, 31, 0, 1'b0);
    run_phase(32'd3, 31, 0, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("modular_exp_and_inverse_unit test passed");
    end else begin
      $display("modular_exp_and_inverse_unit test failed");
    end
    $finish;
  end

endmodule
